@@ design/ftgs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftgs_pkg: shared types and constants for the flex trigger grip sequencer
// Sizes, register indexes, phase codes and controller/datapath link structs.
// ----------------------------------------------------------------------------
package ftgs_pkg;

    localparam int FINGERS     = 4;
    localparam int WINDOW      = 10;
    localparam int SAMPLE_BITS = 12;

    localparam int FW   = 3;                               // finger field width
    localparam int SW   = 12;                              // raw field width
    localparam int SLW  = $clog2(WINDOW);                  // slot index width
    localparam int CW   = $clog2(WINDOW + 1);              // fill count width
    localparam int KW   = (FINGERS > 1) ? $clog2(FINGERS) : 1;
    localparam int MD   = FINGERS * WINDOW;                // window memory depth
    localparam int MAW  = $clog2(MD);
    localparam int SUMW = SAMPLE_BITS + $clog2(WINDOW + 1);
    localparam int QW   = 21;                              // |(avg-open)*100| bits
    localparam int DW   = SAMPLE_BITS + 1;                 // |span| bits

    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_INFLATE = 2'd1,
        PH_HOLD    = 2'd2,
        PH_RELEASE = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        REG_OPEN    = 3'd0,
        REG_CLOSED  = 3'd1,
        REG_TRIGGER = 3'd2,
        REG_REARM   = 3'd3,
        REG_INFLATE = 3'd4,
        REG_HOLD    = 3'd5,
        REG_RELEASE = 3'd6
    } t_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_AVG,
        ST_PCT_PREP,
        ST_PCT_DIV,
        ST_PCT_DONE,
        ST_SEQ,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;        // capture accepted item
        logic mem_wr;      // write sample into window
        logic sum_clr;     // clear accumulator / read index
        logic sum_acc;     // add read data
        logic div_start;   // load a divider
        logic div_pct;     // 1: percent division, 0: average division
        logic div_step;    // one restoring step
        logic pct_upd;     // fold percent into scan max
        logic seq;         // run phase sequencer
        logic out_load;    // load output register
    } t_cmd;

    typedef struct packed {
        logic valid_k;
        logic last;
        logic sum_done;
        logic div_done;
    } t_stat;

endpackage

@@ design/ftgs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftgs_ram: generic single-port RAM
// One write and one registered read of the same address per cycle.
// ----------------------------------------------------------------------------
module ftgs_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/ftgs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftgs_ctrl: sequencing controller
// Steps one item through write, window sum, two divisions and the sequencer.
// ----------------------------------------------------------------------------
module ftgs_ctrl
    import ftgs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_fire,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (i_stat.valid_k) begin
                    o_cmd.mem_wr  = 1'b1;
                    o_cmd.sum_clr = 1'b1;
                    n_state       = ST_SUM_RD;
                end else begin
                    n_state = i_stat.last ? ST_SEQ : ST_IDLE;
                end
            end
            ST_SUM_RD: begin
                n_state = ST_SUM_ACC;
            end
            ST_SUM_ACC: begin
                o_cmd.sum_acc = 1'b1;
                n_state       = i_stat.sum_done ? ST_AVG : ST_SUM_RD;
                if (i_stat.sum_done) begin
                    o_cmd.div_start = 1'b1;
                end
            end
            ST_AVG: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    o_cmd.div_step = 1'b0;
                    n_state        = ST_PCT_PREP;
                end
            end
            ST_PCT_PREP: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_pct   = 1'b1;
                n_state         = ST_PCT_DIV;
            end
            ST_PCT_DIV: begin
                o_cmd.div_pct  = 1'b1;
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    o_cmd.div_step = 1'b0;
                    n_state        = ST_PCT_DONE;
                end
            end
            ST_PCT_DONE: begin
                o_cmd.pct_upd = 1'b1;
                n_state       = i_stat.last ? ST_SEQ : ST_IDLE;
            end
            ST_SEQ: begin
                if (i_out_free) begin
                    o_cmd.seq      = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

@@ design/ftgs_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftgs_dp: datapath
// Window memory, serial sum, shared restoring divider, scan max and phases.
// ----------------------------------------------------------------------------
module ftgs_dp
    import ftgs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [FW-1:0] i_finger,
    input  logic [SW-1:0] i_raw,
    input  logic        i_last,
    input  logic [31:0] i_now,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    output t_stat       o_stat,
    output logic [13:0] o_result
);
    // configuration
    logic [47:0] r_open_cal, r_closed_cal;
    logic [6:0]  r_trig, r_rearm;
    logic [15:0] r_inflate, r_hold, r_release;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_cal   <= '0;
            r_closed_cal <= '1;
            r_trig       <= 7'd60;
            r_rearm      <= 7'd30;
            r_inflate    <= 16'd1000;
            r_hold       <= 16'd3000;
            r_release    <= 16'd1500;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_idx))
                REG_OPEN:    r_open_cal   <= i_cfg_data;
                REG_CLOSED:  r_closed_cal <= i_cfg_data;
                REG_TRIGGER: r_trig       <= i_cfg_data[6:0];
                REG_REARM:   r_rearm      <= i_cfg_data[6:0];
                REG_INFLATE: r_inflate    <= i_cfg_data[15:0];
                REG_HOLD:    r_hold       <= i_cfg_data[15:0];
                REG_RELEASE: r_release    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // captured item
    logic [FW-1:0] r_k;
    logic [SAMPLE_BITS-1:0] r_raw;
    logic          r_last;
    logic [31:0]   r_now;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_k    <= i_finger;
            r_raw  <= i_raw[SAMPLE_BITS-1:0];
            r_last <= i_last;
            r_now  <= i_now;
        end
    end
    logic valid_k;
    assign valid_k = ({29'd0, r_k} < 32'(FINGERS));
    logic [KW-1:0] kk;
    assign kk = r_k[KW-1:0];

    // per finger slot and fill
    logic [SLW-1:0] r_slot [FINGERS];
    logic [CW-1:0]  r_fill [FINGERS];
    logic [CW-1:0]  r_n;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < FINGERS; f++) begin
                r_slot[f] <= '0;
                r_fill[f] <= '0;
            end
        end else if (i_cmd.mem_wr) begin
            r_slot[kk] <= (32'(r_slot[kk]) + 1 >= WINDOW) ? '0 : r_slot[kk] + 1'b1;
            if (32'(r_fill[kk]) < WINDOW) begin
                r_fill[kk] <= r_fill[kk] + 1'b1;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_n <= (32'(r_fill[kk]) < WINDOW) ? r_fill[kk] + 1'b1 : r_fill[kk];
        end
    end

    // window memory and serial sum
    logic [SLW-1:0] r_idx;
    logic [SUMW-1:0] r_sum;
    logic [MAW-1:0] base, addr;
    logic [SAMPLE_BITS-1:0] rdata;
    assign base = MAW'(32'(kk) * WINDOW);
    assign addr = base + MAW'(i_cmd.mem_wr ? r_slot[kk] : r_idx);

    ftgs_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MD)) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.mem_wr),
        .i_addr (addr),
        .i_wdata(r_raw),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_clr) begin
            r_idx <= '0;
            r_sum <= '0;
        end else if (i_cmd.sum_acc) begin
            r_sum <= r_sum + SUMW'(rdata);
            r_idx <= r_idx + 1'b1;
        end
    end
    logic sum_done;
    assign sum_done = (CW'(r_idx) + 1'b1 >= r_n);

    // calibration select
    logic [SAMPLE_BITS-1:0] open_v, closed_v;
    always_comb begin
        open_v   = '0;
        closed_v = '0;
        for (int f = 0; f < FINGERS; f++) begin
            if (kk == KW'(f) && f < 4) begin
                open_v   = r_open_cal[12*(f%4) +: SAMPLE_BITS];
                closed_v = r_closed_cal[12*(f%4) +: SAMPLE_BITS];
            end
        end
    end

    // shared restoring divider on magnitudes
    logic [QW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_dvs;
    logic [4:0]    r_cnt;
    logic          r_neg;
    logic [SAMPLE_BITS-1:0] r_avg;

    logic signed [13:0] diff, span;
    logic signed [20:0] numer;
    assign diff  = $signed({2'b0, r_avg}) - $signed({2'b0, open_v});
    assign span  = ($signed({2'b0, closed_v}) == $signed({2'b0, open_v})) ? 14'sd1
                 : $signed({2'b0, closed_v}) - $signed({2'b0, open_v});
    assign numer = 21'(diff) * 21'sd100;

    logic [DW:0] trial;
    assign trial = {r_rem[DW-1:0], r_q[QW-1]} - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_cnt <= '0;
            if (i_cmd.div_pct) begin
                r_q   <= numer[20] ? QW'(-numer) : QW'(numer);
                r_dvs <= span[13] ? DW'(-span) : DW'(span);
                r_neg <= numer[20] ^ span[13];
            end else begin
                r_q   <= QW'(r_sum) + QW'(rdata);
                r_dvs <= DW'(r_n);
                r_neg <= 1'b0;
            end
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (!trial[DW]) begin
                r_rem <= trial;
                r_q   <= {r_q[QW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[DW-1:0], r_q[QW-1]};
                r_q   <= {r_q[QW-2:0], 1'b0};
            end
        end
    end
    logic div_done;
    assign div_done = (r_cnt == 5'(QW));

    always_ff @(posedge i_clk) begin
        if (div_done && !i_cmd.div_pct && !i_cmd.div_start) begin
            r_avg <= r_q[SAMPLE_BITS-1:0];
        end
    end

    // scan max and phase sequencer
    logic [6:0] pct;
    always_comb begin
        if (r_neg && r_q != '0) begin
            pct = 7'd0;
        end else if (r_q > QW'(100)) begin
            pct = 7'd100;
        end else begin
            pct = r_q[6:0];
        end
    end

    logic [6:0]  r_max;
    t_phase      r_phase;
    logic        r_armed;
    logic [31:0] r_start;
    logic [13:0] r_res;
    logic [31:0] elapsed;
    assign elapsed = r_now - r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= '0;
            r_phase <= PH_WAIT;
            r_armed <= 1'b1;
            r_start <= '0;
        end else if (i_cmd.pct_upd) begin
            if (pct > r_max) r_max <= pct;
        end else if (i_cmd.seq) begin
            r_max <= '0;
            case (r_phase)
                PH_WAIT: begin
                    if ((r_max <= r_rearm || r_armed) && r_max >= r_trig) begin
                        r_armed <= 1'b0;
                        r_phase <= PH_INFLATE;
                        r_start <= r_now;
                    end else if (r_max <= r_rearm) begin
                        r_armed <= 1'b1;
                    end
                end
                PH_INFLATE: if (elapsed >= {16'd0, r_inflate}) begin
                    r_phase <= PH_HOLD;
                    r_start <= r_now;
                end
                PH_HOLD: if (elapsed >= {16'd0, r_hold}) begin
                    r_phase <= PH_RELEASE;
                    r_start <= r_now;
                end
                default: if (elapsed >= {16'd0, r_release}) begin
                    r_phase <= PH_WAIT;
                    r_start <= r_now;
                end
            endcase
        end
    end

    // next phase and armed as they will be after the sequencer step
    t_phase nph;
    logic   narm;
    always_comb begin
        nph  = r_phase;
        narm = r_armed;
        case (r_phase)
            PH_WAIT: begin
                if (r_max <= r_rearm) narm = 1'b1;
                if (narm && r_max >= r_trig) begin
                    narm = 1'b0;
                    nph  = PH_INFLATE;
                end
            end
            PH_INFLATE: if (elapsed >= {16'd0, r_inflate}) nph = PH_HOLD;
            PH_HOLD:    if (elapsed >= {16'd0, r_hold})    nph = PH_RELEASE;
            default:    if (elapsed >= {16'd0, r_release}) nph = PH_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_res <= {narm, nph, (r_phase == PH_RELEASE), (r_phase == PH_INFLATE),
                      r_phase, r_max};
        end
    end

    assign o_result = r_res;
    assign o_stat   = '{valid_k: valid_k, last: r_last, sum_done: sum_done,
                        div_done: div_done};
endmodule

@@ design/flex_trigger_grip_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flex_trigger_grip_sequencer: flex-sensor triggered pneumatic grip sequencer
// Moving-average bend percent per finger drives a wait/inflate/hold/release
// valve sequence once per scan.
// ----------------------------------------------------------------------------
// One sample transfer runs a write, a window sum over up to ten filled slots,
// which reads the memory one slot at a time, and one shared restoring divider
// for 21 steps for the average and 21 for the percent; no new sample is taken
// before it ends. Out-of-range fingers skip the write, sum and divisions. A
// scan-end transfer also runs the phase sequencer and produces one result transfer.
// Input tdata: finger[2:0], raw_sample[14:3], now_ms[46:15], zero pad to 48;
// tlast is scan_end. Output tdata: max_pct[6:0], acting_phase[8:7],
// inlet_open[9], exhaust_open[10], next_phase[12:11], armed_flag[13], pad 16.
// Write configuration only while no transfer is in flight.
module flex_trigger_grip_sequencer
    import ftgs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // finger, raw_sample, now_ms
    input  logic        s_axis_tlast,   // scan_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // max_pct, acting_phase, inlet, exhaust, next, armed
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data
);
    t_cmd  cmd;
    t_stat stat;
    logic  in_fire;
    logic  r_ovalid;
    logic [13:0] result;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    ftgs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_fire (in_fire),
        .i_out_free(!r_ovalid || m_axis_tready),
        .i_stat    (stat),
        .o_in_ready(s_axis_tready),
        .o_cmd     (cmd)
    );

    ftgs_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_finger  (s_axis_tdata[2:0]),
        .i_raw     (s_axis_tdata[14:3]),
        .i_last    (s_axis_tlast),
        .i_now     (s_axis_tdata[46:15]),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_stat    (stat),
        .o_result  (result)
    );

    // hold the result until the downstream transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, result};
endmodule
